// File: sv/s5c_pkg.sv
// shared types and constants for the socks5 connect handshake block
package s5c_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_PORT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOST_LENGTH = 1'd1;

	// input opcodes
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_HOST   = 2'd1;
	localparam logic [1:0] OP_SERVER = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;

	// protocol bytes
	localparam logic [7:0] SOCKS_VER   = 8'h05;
	localparam logic [7:0] CMD_CONNECT = 8'h01;
	localparam logic [7:0] METHOD_NONE = 8'h00;
	localparam logic [7:0] RSV_BYTE    = 8'h00;
	localparam logic [7:0] REP_SUCCESS = 8'h00;
	localparam logic [7:0] ATYP_IPV4   = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN = 8'h03;
	localparam logic [7:0] IPV4_LEN    = 8'd4;
	localparam logic [7:0] PORT_LEN    = 8'd2;

	// command queue between front and back
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// kind of output run that one item causes
	typedef enum logic [2:0] {
		RUN_GREET   = 3'd0,
		RUN_REQUEST = 3'd1,
		RUN_HOST    = 3'd2,
		RUN_OK      = 3'd3,
		RUN_FAIL    = 3'd4
	} run_t;

	typedef struct packed {
		run_t        run;
		logic [7:0]  data;
		logic        with_port;
		logic [15:0] port;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} fifo_stat_t;

endpackage

// File: sv/s5c_ifs.sv
// handshake channel interfaces for items and results
interface s5c_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface s5c_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] tx_byte;
	logic       last_of_run;

	modport source (output valid, output result_kind, output tx_byte, output last_of_run,
		input ready);
	modport sink (input valid, input result_kind, input tx_byte, input last_of_run,
		output ready);
endinterface

// File: sv/socks5_connect_handshake.sv
// top level of the socks5 connect client handshake block
//
// The item channel takes one transaction per cycle: opcode start, host-name
// byte or byte received from the server, with data_byte. The result channel
// gives the bytes to transmit and a success or failure mark, each with
// last_of_run set on the final result of the item that caused it; items
// that cause nothing give no result.
// Configuration (target_port, host_length) is written over cfg_we, cfg_index
// and cfg_data, by the user only while the block is idle; nothing checks this.
// A front end tracks the handshake phase and issues at most one command per
// item into a four-entry queue; a back end expands each command into one to
// seven results, one per cycle unless stalled, through an output register.
// An item's command is registered in the queue and then in the back end's
// command register, and its first result in the output register.
// Throughput: one item per cycle while the queue has room; the result port
// moves one result per cycle, so items with longer runs set the sustained rate.
// When the receiver stalls, the output register holds its result, the queue
// fills and item ready drops once four commands are waiting.
// Reset clears the phase to idle, the queue and the output valid, and both
// configuration registers to zero.
module socks5_connect_handshake (
	input  logic                            clk,
	input  logic                            arst_n,
	s5c_item_if.sink                        item,
	s5c_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [s5c_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [s5c_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import s5c_pkg::*;

	fifo_stat_t q_stat;
	logic       push;
	cmd_t       push_cmd;
	logic       pop;
	cmd_t       head;

	// classify transactions and issue commands
	s5c_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// command queue
	s5c_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	// expand commands into results
	s5c_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_head(head),
		.q_pop (pop),
		.result(result)
	);

endmodule

// File: sv/s5c_front.sv
// front end: config registers, handshake state tracking and command issue
module s5c_front (
	input  logic                            clk,
	input  logic                            arst_n,
	s5c_item_if.sink                        item,
	input  logic                            cfg_we,
	input  logic [s5c_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [s5c_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  s5c_pkg::fifo_stat_t             q_stat,
	output logic                            push,
	output s5c_pkg::cmd_t                   push_cmd
);
	import s5c_pkg::*;

	typedef enum logic [10:0] {
		PH_IDLE   = 11'b000_0000_0001,
		PH_G_VER  = 11'b000_0000_0010,
		PH_G_METH = 11'b000_0000_0100,
		PH_HOST   = 11'b000_0000_1000,
		PH_R_VER  = 11'b000_0001_0000,
		PH_R_STAT = 11'b000_0010_0000,
		PH_R_RSV  = 11'b000_0100_0000,
		PH_R_ATYP = 11'b000_1000_0000,
		PH_R_NLEN = 11'b001_0000_0000,
		PH_R_ADDR = 11'b010_0000_0000,
		PH_R_PORT = 11'b100_0000_0000
	} phase_t;

	logic [15:0] target_port_q;
	logic [7:0]  host_length_q;
	phase_t      phase_q, phase_d;
	logic [7:0]  host_count_q, host_count_d;
	logic [7:0]  skip_q, skip_d;
	logic [7:0]  host_count_inc;
	logic [7:0]  skip_dec;
	logic        acc;

	assign item.ready     = !q_stat.full;
	assign acc            = item.valid && item.ready;
	assign host_count_inc = host_count_q + 8'd1;
	assign skip_dec       = skip_q - 8'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_port_q <= '0;
			host_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET_PORT: target_port_q <= cfg_data;
				CFG_HOST_LENGTH: host_length_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// next state and command for one accepted transaction
	always_comb begin
		phase_d            = phase_q;
		host_count_d       = host_count_q;
		skip_d             = skip_q;
		push               = 1'b0;
		push_cmd.run       = RUN_FAIL;
		push_cmd.data      = item.data_byte;
		push_cmd.with_port = 1'b0;
		push_cmd.port      = target_port_q;
		if (acc) begin
			case (item.opcode)
				OP_START: begin
					push         = 1'b1;
					push_cmd.run = RUN_GREET;
					host_count_d = '0;
					skip_d       = '0;
					phase_d      = PH_G_VER;
				end
				OP_HOST: begin
					if (phase_q == PH_HOST) begin
						push               = 1'b1;
						push_cmd.run       = RUN_HOST;
						host_count_d       = host_count_inc;
						push_cmd.with_port = (host_count_inc == 8'd0) ||
							(host_count_inc >= host_length_q);
						if (push_cmd.with_port) begin
							phase_d = PH_R_VER;
						end
					end
				end
				OP_SERVER: begin
					case (phase_q)
						PH_G_VER: begin
							if (item.data_byte != SOCKS_VER) begin
								push    = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_G_METH;
							end
						end
						PH_G_METH: begin
							push = 1'b1;
							if (item.data_byte != METHOD_NONE) begin
								phase_d = PH_IDLE;
							end else begin
								push_cmd.run       = RUN_REQUEST;
								push_cmd.data      = host_length_q;
								push_cmd.with_port = (host_length_q == 8'd0);
								host_count_d       = '0;
								phase_d            = push_cmd.with_port ? PH_R_VER : PH_HOST;
							end
						end
						PH_R_VER: begin
							if (item.data_byte != SOCKS_VER) begin
								push    = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_R_STAT;
							end
						end
						PH_R_STAT: begin
							if (item.data_byte != REP_SUCCESS) begin
								push    = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_R_RSV;
							end
						end
						PH_R_RSV: begin
							phase_d = PH_R_ATYP;
						end
						PH_R_ATYP: begin
							if (item.data_byte == ATYP_IPV4) begin
								skip_d  = IPV4_LEN;
								phase_d = PH_R_ADDR;
							end else if (item.data_byte == ATYP_DOMAIN) begin
								phase_d = PH_R_NLEN;
							end else begin
								push    = 1'b1;
								phase_d = PH_IDLE;
							end
						end
						PH_R_NLEN: begin
							if (item.data_byte == 8'd0) begin
								skip_d  = PORT_LEN;
								phase_d = PH_R_PORT;
							end else begin
								skip_d  = item.data_byte;
								phase_d = PH_R_ADDR;
							end
						end
						PH_R_ADDR: begin
							if (skip_dec == 8'd0) begin
								skip_d  = PORT_LEN;
								phase_d = PH_R_PORT;
							end else begin
								skip_d = skip_dec;
							end
						end
						PH_R_PORT: begin
							skip_d = skip_dec;
							if (skip_dec == 8'd0) begin
								push         = 1'b1;
								push_cmd.run = RUN_OK;
								phase_d      = PH_IDLE;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			host_count_q <= '0;
			skip_q       <= '0;
		end else begin
			phase_q      <= phase_d;
			host_count_q <= host_count_d;
			skip_q       <= skip_d;
		end
	end

	// a command is only issued for an accepted transaction
	assert property (@(posedge clk) disable iff (!arst_n) push |-> acc)
		else $error("command issued without an accepted transaction");

endmodule

// File: sv/s5c_fifo.sv
// short command queue between the front and back ends
module s5c_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  s5c_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output s5c_pkg::cmd_t       head,
	output s5c_pkg::fifo_stat_t stat
);
	import s5c_pkg::*;

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign head           = mem_q[rd_ptr_q];
	assign stat.full      = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign stat.not_empty = (count_q != '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n) push |-> (!stat.full || pop))
		else $error("push into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> stat.not_empty)
		else $error("pop from an empty queue");

endmodule

// File: sv/s5c_back.sv
// back end: expands queued commands into results, one per cycle when not stalled
module s5c_back (
	input  logic                clk,
	input  logic                arst_n,
	input  s5c_pkg::fifo_stat_t q_stat,
	input  s5c_pkg::cmd_t       q_head,
	output logic                q_pop,
	s5c_result_if.source        result
);
	import s5c_pkg::*;

	localparam int STEP_W = 3;

	cmd_t              cur_q;
	logic              cur_valid_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [1:0]        out_kind_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic [1:0]        r_kind;
	logic [7:0]        r_byte;
	logic              r_last;
	logic              load;
	logic              take;

	// result for the current command and step
	always_comb begin
		r_kind = KIND_TX;
		r_byte = '0;
		r_last = 1'b0;
		case (cur_q.run)
			RUN_GREET: begin
				case (step_q)
					3'd0:    r_byte = SOCKS_VER;
					3'd1:    r_byte = CMD_CONNECT;
					default: r_byte = METHOD_NONE;
				endcase
				r_last = (step_q == 3'd2);
			end
			RUN_REQUEST: begin
				case (step_q)
					3'd0:    r_byte = SOCKS_VER;
					3'd1:    r_byte = CMD_CONNECT;
					3'd2:    r_byte = RSV_BYTE;
					3'd3:    r_byte = ATYP_DOMAIN;
					3'd4:    r_byte = cur_q.data;
					3'd5:    r_byte = cur_q.port[15:8];
					default: r_byte = cur_q.port[7:0];
				endcase
				r_last = cur_q.with_port ? (step_q == 3'd6) : (step_q == 3'd4);
			end
			RUN_HOST: begin
				case (step_q)
					3'd0:    r_byte = cur_q.data;
					3'd1:    r_byte = cur_q.port[15:8];
					default: r_byte = cur_q.port[7:0];
				endcase
				r_last = cur_q.with_port ? (step_q == 3'd2) : (step_q == 3'd0);
			end
			RUN_OK: begin
				r_kind = KIND_OK;
				r_last = 1'b1;
			end
			default: begin
				r_kind = KIND_FAIL;
				r_last = 1'b1;
			end
		endcase
	end

	// output register loads when empty or drained; next command follows a last result
	assign load  = !out_valid_q || result.ready;
	assign take  = q_stat.not_empty && (!cur_valid_q || (load && r_last));
	assign q_pop = take;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= cur_valid_q;
			end
			if (load && cur_valid_q) begin
				step_q <= r_last ? '0 : step_q + 1'b1;
			end
			if (take) begin
				cur_valid_q <= 1'b1;
			end else if (load && cur_valid_q && r_last) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && cur_valid_q) begin
			out_kind_q <= r_kind;
			out_byte_q <= r_byte;
			out_last_q <= r_last;
		end
		if (take) begin
			cur_q <= q_head;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.tx_byte     = out_byte_q;
	assign result.last_of_run = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n) cur_valid_q |-> (step_q <= 3'd6))
		else $error("step index beyond longest run");

	assert property (@(posedge clk) disable iff (!arst_n) (load && cur_valid_q) |=> out_valid_q)
		else $error("computed result not presented");

endmodule

// File: bench/testbench.sv
// self-checking bench for the socks5 connect client handshake block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import s5c_pkg::*;

	// opcode that the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// cycles with no transaction on either channel before giving up
	localparam int STALL_LIMIT = 2000;
	// length of the one long receiver hold-off
	localparam int CHOKE_CYCLES = 120;
	// cycles left after draining for commands that give no result
	localparam int SETTLE_CYCLES = 12;

	typedef enum logic [3:0] {
		P_IDLE, P_G_VER, P_G_METH, P_HOST, P_R_VER, P_R_STAT,
		P_R_RSV, P_R_ATYP, P_R_NLEN, P_R_ADDR, P_R_PORT
	} client_phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx;
		logic       last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	s5c_item_if   item_ch ();
	s5c_result_if result_ch ();

	socks5_connect_handshake dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// items waiting to be offered and results the block still owes
	item_t outgoing[$];
	res_t  owed[$];
	res_t  run_buf[$];

	// shadow of the block: configuration and handshake progress
	logic [15:0]   port_cfg = '0;
	logic [7:0]    host_len_cfg = '0;
	client_phase_t phase = P_IDLE;
	logic [7:0]    host_cnt = '0;
	logic [7:0]    skip_left = '0;

	int mismatches = 0;
	int tally = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit steady = 1'b0;
	bit choke_req = 1'b0;
	bit choke_done = 1'b0;

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one result of the current item, at most eight per item
	function automatic void put(logic [1:0] kind, logic [7:0] tx);
		if (run_buf.size() < 8) begin
			run_buf.push_back('{kind, tx, 1'b0});
		end
	endfunction

	function automatic void put_port();
		put(KIND_TX, port_cfg[15:8]);
		put(KIND_TX, port_cfg[7:0]);
		phase = P_R_VER;
	endfunction

	// expected results of one accepted item
	function automatic void handshake_step(logic [1:0] op, logic [7:0] b);
		case (op)
			OP_START: begin
				put(KIND_TX, SOCKS_VER);
				put(KIND_TX, CMD_CONNECT);
				put(KIND_TX, METHOD_NONE);
				host_cnt = '0;
				skip_left = '0;
				phase = P_G_VER;
			end
			OP_HOST: begin
				if (phase == P_HOST) begin
					put(KIND_TX, b);
					host_cnt = host_cnt + 8'd1;
					if (host_cnt == 8'd0 || host_cnt >= host_len_cfg) begin
						put_port();
					end
				end
			end
			OP_SERVER: begin
				case (phase)
					P_G_VER: begin
						if (b != SOCKS_VER) begin
							put(KIND_FAIL, 8'h00);
							phase = P_IDLE;
						end else begin
							phase = P_G_METH;
						end
					end
					P_G_METH: begin
						if (b != METHOD_NONE) begin
							put(KIND_FAIL, 8'h00);
							phase = P_IDLE;
						end else begin
							put(KIND_TX, SOCKS_VER);
							put(KIND_TX, CMD_CONNECT);
							put(KIND_TX, RSV_BYTE);
							put(KIND_TX, ATYP_DOMAIN);
							put(KIND_TX, host_len_cfg);
							host_cnt = '0;
							if (host_len_cfg == 8'd0) begin
								put_port();
							end else begin
								phase = P_HOST;
							end
						end
					end
					P_R_VER: begin
						if (b != SOCKS_VER) begin
							put(KIND_FAIL, 8'h00);
							phase = P_IDLE;
						end else begin
							phase = P_R_STAT;
						end
					end
					P_R_STAT: begin
						if (b != REP_SUCCESS) begin
							put(KIND_FAIL, 8'h00);
							phase = P_IDLE;
						end else begin
							phase = P_R_RSV;
						end
					end
					P_R_RSV: begin
						phase = P_R_ATYP;
					end
					P_R_ATYP: begin
						if (b == ATYP_IPV4) begin
							skip_left = IPV4_LEN;
							phase = P_R_ADDR;
						end else if (b == ATYP_DOMAIN) begin
							phase = P_R_NLEN;
						end else begin
							put(KIND_FAIL, 8'h00);
							phase = P_IDLE;
						end
					end
					P_R_NLEN: begin
						skip_left = b;
						if (b == 8'd0) begin
							skip_left = PORT_LEN;
							phase = P_R_PORT;
						end else begin
							phase = P_R_ADDR;
						end
					end
					P_R_ADDR: begin
						skip_left = skip_left - 8'd1;
						if (skip_left == 8'd0) begin
							skip_left = PORT_LEN;
							phase = P_R_PORT;
						end
					end
					P_R_PORT: begin
						skip_left = skip_left - 8'd1;
						if (skip_left == 8'd0) begin
							put(KIND_OK, 8'h00);
							phase = P_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		// mark the end of the run and hand it over
		if (run_buf.size() > 0) begin
			run_buf[run_buf.size()-1].last = 1'b1;
		end
		foreach (run_buf[i]) begin
			owed.push_back(run_buf[i]);
		end
		run_buf.delete();
	endfunction

	// item driver: holds an offer until taken, predicts on every transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				handshake_step(item_ch.opcode, item_ch.data_byte);
				void'(outgoing.pop_front());
			end
			if (item_ch.valid && !item_ch.ready) begin
				// keep offering the same transaction
			end else if (outgoing.size() > 0 && (steady || $urandom_range(0, 99) >= 11)) begin
				item_ch.valid <= 1'b1;
				item_ch.opcode <= outgoing[0].op;
				item_ch.data_byte <= outgoing[0].data;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		res_t w;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (owed.size() == 0) begin
					$display("%0t ns: unexpected result: expected none, got kind %0d byte %h last %0b",
						$time, result_ch.result_kind, result_ch.tx_byte, result_ch.last_of_run);
					mismatches++;
				end else begin
					w = owed.pop_front();
					if (result_ch.result_kind !== w.kind) begin
						$display("%0t ns: result_kind expected %0d got %0d",
							$time, w.kind, result_ch.result_kind);
						mismatches++;
					end
					if (result_ch.tx_byte !== w.tx) begin
						$display("%0t ns: tx_byte expected %h got %h",
							$time, w.tx, result_ch.tx_byte);
						mismatches++;
					end
					if (result_ch.last_of_run !== w.last) begin
						$display("%0t ns: last_of_run expected %0b got %0b",
							$time, w.last, result_ch.last_of_run);
						mismatches++;
					end
				end
			end
			// one long hold-off so the queue fills and item ready drops
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (choke_req && !choke_done) begin
				choke_done <= 1'b1;
				hold_left <= CHOKE_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || $urandom_range(0, 99) >= 11;
			end
		end
	end

	// watchdog on transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic put_item(logic [1:0] op, logic [7:0] d);
		outgoing.push_back('{op, d});
	endtask

	// wait until every item is taken and every result has come back
	task automatic settle();
		do begin
			@(negedge clk);
		end while (outgoing.size() != 0 || item_ch.valid || owed.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_TARGET_PORT) begin
			port_cfg = val;
		end else begin
			host_len_cfg = val[7:0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one handshake with random content, now and then broken or padded with noise
	task automatic random_handshake();
		item_t seq[$];
		int sel;
		int nlen;
		int pos;
		seq.push_back('{OP_START, 8'($urandom)});
		seq.push_back('{OP_SERVER, SOCKS_VER});
		seq.push_back('{OP_SERVER, METHOD_NONE});
		repeat (host_len_cfg) seq.push_back('{OP_HOST, 8'($urandom)});
		seq.push_back('{OP_SERVER, SOCKS_VER});
		seq.push_back('{OP_SERVER, REP_SUCCESS});
		seq.push_back('{OP_SERVER, 8'($urandom)});
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			seq.push_back('{OP_SERVER, ATYP_IPV4});
			repeat (4) seq.push_back('{OP_SERVER, 8'($urandom)});
		end else if (sel < 9) begin
			nlen = $urandom_range(0, 6);
			seq.push_back('{OP_SERVER, ATYP_DOMAIN});
			seq.push_back('{OP_SERVER, 8'(nlen)});
			repeat (nlen) seq.push_back('{OP_SERVER, 8'($urandom)});
		end else begin
			seq.push_back('{OP_SERVER, 8'($urandom)});
		end
		repeat (2) seq.push_back('{OP_SERVER, 8'($urandom)});
		// sometimes corrupt one byte of the sequence
		if ($urandom_range(0, 4) == 0) begin
			pos = $urandom_range(1, seq.size() - 1);
			seq[pos].data = 8'($urandom);
		end
		foreach (seq[i]) begin
			if ($urandom_range(0, 99) < 6) begin
				sel = $urandom_range(0, 2);
				put_item(sel == 0 ? OP_UNUSED : (sel == 1 ? OP_HOST : OP_START), 8'($urandom));
			end
			outgoing.push_back(seq[i]);
			tally++;
		end
	endtask

	// reset, directed cases, random handshakes, verdict
	initial begin
		int hs;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = '0;
		item_ch.data_byte = '0;
		result_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero host length, ignored items, zero-length reply name
		cfg_write(CFG_TARGET_PORT, 16'hFFFF);
		cfg_write(CFG_HOST_LENGTH, 16'd0);
		put_item(OP_UNUSED, 8'hFF);
		put_item(OP_HOST, 8'h00);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_START, 8'hFF);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_SERVER, METHOD_NONE);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_SERVER, REP_SUCCESS);
		put_item(OP_SERVER, 8'hAA);
		put_item(OP_SERVER, ATYP_DOMAIN);
		put_item(OP_SERVER, 8'h00);
		put_item(OP_SERVER, 8'h5A);
		put_item(OP_SERVER, 8'hA5);
		settle();

		// restart while busy, server byte during the host name
		cfg_write(CFG_TARGET_PORT, 16'h0000);
		cfg_write(CFG_HOST_LENGTH, 16'd3);
		put_item(OP_START, 8'h00);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_START, 8'h7E);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_SERVER, METHOD_NONE);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_HOST, 8'hFF);
		settle();

		// host length cut to the number of bytes already sent, then a bad address type
		cfg_write(CFG_HOST_LENGTH, 16'd1);
		put_item(OP_HOST, 8'h00);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_SERVER, REP_SUCCESS);
		put_item(OP_SERVER, 8'h00);
		put_item(OP_SERVER, 8'h04);
		settle();

		// random handshakes over changing settings
		hs = 0;
		while (tally < 85) begin
			settle();
			if (hs % 2 == 0) begin
				case ($urandom_range(0, 3))
					0: cfg_write(CFG_TARGET_PORT, 16'h0000);
					1: cfg_write(CFG_TARGET_PORT, 16'hFFFF);
					default: cfg_write(CFG_TARGET_PORT, 16'($urandom));
				endcase
			end
			cfg_write(CFG_HOST_LENGTH, 16'($urandom_range(0, 6)));
			steady = (hs >= 1 && hs <= 4);
			random_handshake();
			if (hs == 2) begin
				choke_req = 1'b1;
			end
			hs++;
		end

		// longest host name, cut short part way through, then a refused reply
		settle();
		steady = 1'b0;
		cfg_write(CFG_TARGET_PORT, 16'h8001);
		cfg_write(CFG_HOST_LENGTH, 16'd255);
		put_item(OP_START, 8'h00);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_SERVER, METHOD_NONE);
		put_item(OP_HOST, 8'h61);
		put_item(OP_HOST, 8'h62);
		settle();
		cfg_write(CFG_HOST_LENGTH, 16'd2);
		put_item(OP_HOST, 8'h63);
		put_item(OP_SERVER, SOCKS_VER);
		put_item(OP_SERVER, 8'h01);
		settle();

		if (mismatches == 0 && owed.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/s5c_pkg.sv
sv/s5c_ifs.sv
sv/s5c_front.sv
sv/s5c_fifo.sv
sv/s5c_back.sv
sv/socks5_connect_handshake.sv
bench/testbench.sv
